// File: design/bpsc_pkg.sv
// Shared types, codes and helpers of the battery power-state controller.
package bpsc_pkg;

    // Item kinds as they arrive on the input queue
    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_SAMPLE   = 2'd1,
        KIND_ACTIVITY = 2'd2,
        KIND_WAKE     = 2'd3
    } t_kind;

    // Power modes
    typedef enum logic [2:0] {
        MODE_ACTIVE = 3'd0,
        MODE_MOTION = 3'd1,
        MODE_LIGHT  = 3'd2,
        MODE_DEEP   = 3'd3,
        MODE_LOW    = 3'd4,
        MODE_CRIT   = 3'd5,
        MODE_USB    = 3'd6
    } t_mode;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_EXEC,
        SEQ_MUL,
        SEQ_DIV,
        SEQ_CONV,
        SEQ_ACC,
        SEQ_AVG,
        SEQ_PCT,
        SEQ_EMIT
    } t_seq;

    // Configuration register indexes
    localparam logic [2:0] CFG_IDLE_TO_LIGHT = 3'd0;
    localparam logic [2:0] CFG_LIGHT_TO_DEEP = 3'd1;
    localparam logic [2:0] CFG_LOW_TH        = 3'd2;
    localparam logic [2:0] CFG_CRIT_TH       = 3'd3;
    localparam logic [2:0] CFG_CAL_OFFSET    = 3'd4;
    localparam logic [2:0] CFG_AUTO_SLEEP    = 3'd5;
    localparam logic [2:0] CFG_DEEP_SLEEP    = 3'd6;
    localparam logic [2:0] CFG_MONITOR       = 3'd7;

    localparam int CFG_DATA_W = 22;

    // Conversion and curve constants
    localparam logic [12:0] ADC_SCALE   = 13'd6600;  // 2 x 3.3 V full scale in mV
    localparam logic [24:0] ADC_ROUND   = 25'd2047;
    localparam logic [12:0] ADC_FULL    = 13'd4095;
    localparam logic [12:0] MV_NOMINAL  = 13'd3800;
    localparam logic [12:0] MV_FULL     = 13'd4200;
    localparam logic [12:0] MV_KNEE     = 13'd3700;
    localparam logic [12:0] MV_EMPTY    = 13'd3000;
    localparam logic [12:0] MV_MAX      = 13'd8191;
    localparam logic [12:0] RECIP_10    = 13'd6554;  // ceil(2^16 / 10)
    localparam logic [12:0] RECIP_14    = 13'd4682;  // ceil(2^16 / 14)

    typedef struct packed {
        logic [21:0]        idle_to_light_ms;
        logic [21:0]        light_to_deep_ms;
        logic [12:0]        low_threshold_mv;
        logic [12:0]        critical_threshold_mv;
        logic signed [10:0] calibration_offset_mv;
        logic               auto_sleep_enable;
        logic               deep_sleep_enable;
        logic               monitoring_enable;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [11:0] adc_raw;
        logic        vbus_high;
        logic        wake_motion;
    } t_cmd;

    typedef struct packed {
        t_mode       power_mode;
        logic [12:0] filtered_mv;
        logic [6:0]  charge_percent;
        logic        battery_low;
        logic        battery_critical;
        logic        usb_present;
        logic        low_event;
        logic        critical_event;
        logic        usb_connect_event;
        logic [31:0] wake_total;
        logic [31:0] sleep_entry_total;
    } t_result;

    // Saturating increment of a 32-bit count
    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

// File: design/battery_power_state_controller_core.sv
// Top level of the battery power-state controller: config registers, front and back.
//
//  Channel   Direction  Handshake               Beat
//  input     in         push / full             kind, adc_raw, vbus_high, wake_source
//  result    out        empty / pop             mode, voltage, percent, flags, events, totals
//  config    in         i_cfg_we (no wait)      i_cfg_idx, i_cfg_data
//
//  Tick, activity and wake beats go from queue head through the EXEC and EMIT states.
//  Sample beats also pass MUL, DIV, CONV, ACC, the bit-serial average divider in AVG
//  over the SUM_W = 13 + clog2(SAMPLE_DEPTH+1) bits of the sum, and PCT.
//  One beat is in the sequencer at a time; two-entry queues sit on each side.
//  Reset is synchronous and clears modes, counters, averages and both queues.
//  A full result queue stalls the sequencer; the input queue keeps accepting until full.
module battery_power_state_controller_core
    import bpsc_pkg::*;
#(
    parameter int SAMPLE_DEPTH = 8,
    parameter int GRACE_MS     = 10000
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            i_kind,
    input  logic [11:0]           i_adc_raw,
    input  logic                  i_vbus_high,
    input  logic [1:0]            i_wake_source,
    output logic                  empty,
    input  logic                  pop,
    output logic [2:0]            o_power_mode,
    output logic [12:0]           o_filtered_mv,
    output logic [6:0]            o_charge_percent,
    output logic                  o_battery_low,
    output logic                  o_battery_critical,
    output logic                  o_usb_present,
    output logic                  o_low_event,
    output logic                  o_critical_event,
    output logic                  o_usb_connect_event,
    output logic [31:0]           o_wake_total,
    output logic [31:0]           o_sleep_entry_total,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    logic    w_cmd_valid;
    t_cmd    w_cmd;
    logic    w_cmd_pop;
    t_result w_res;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_to_light_ms      <= 22'd180000;
            r_cfg.light_to_deep_ms      <= 22'd60000;
            r_cfg.low_threshold_mv      <= 13'd3400;
            r_cfg.critical_threshold_mv <= 13'd3200;
            r_cfg.calibration_offset_mv <= 11'sd0;
            r_cfg.auto_sleep_enable     <= 1'b1;
            r_cfg.deep_sleep_enable     <= 1'b1;
            r_cfg.monitoring_enable     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDLE_TO_LIGHT: r_cfg.idle_to_light_ms      <= i_cfg_data[21:0];
                CFG_LIGHT_TO_DEEP: r_cfg.light_to_deep_ms      <= i_cfg_data[21:0];
                CFG_LOW_TH:        r_cfg.low_threshold_mv      <= i_cfg_data[12:0];
                CFG_CRIT_TH:       r_cfg.critical_threshold_mv <= i_cfg_data[12:0];
                CFG_CAL_OFFSET:    r_cfg.calibration_offset_mv <= $signed(i_cfg_data[10:0]);
                CFG_AUTO_SLEEP:    r_cfg.auto_sleep_enable     <= i_cfg_data[0];
                CFG_DEEP_SLEEP:    r_cfg.deep_sleep_enable     <= i_cfg_data[0];
                CFG_MONITOR:       r_cfg.monitoring_enable     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    bpsc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_kind        (i_kind),
        .i_adc_raw     (i_adc_raw),
        .i_vbus_high   (i_vbus_high),
        .i_wake_source (i_wake_source),
        .o_cmd_valid   (w_cmd_valid),
        .o_cmd         (w_cmd),
        .i_cmd_pop     (w_cmd_pop)
    );

    bpsc_back #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH),
        .GRACE_MS     (GRACE_MS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .o_res       (w_res)
    );

    // Unpack the result beat
    assign o_power_mode        = w_res.power_mode;
    assign o_filtered_mv       = w_res.filtered_mv;
    assign o_charge_percent    = w_res.charge_percent;
    assign o_battery_low       = w_res.battery_low;
    assign o_battery_critical  = w_res.battery_critical;
    assign o_usb_present       = w_res.usb_present;
    assign o_low_event         = w_res.low_event;
    assign o_critical_event    = w_res.critical_event;
    assign o_usb_connect_event = w_res.usb_connect_event;
    assign o_wake_total        = w_res.wake_total;
    assign o_sleep_entry_total = w_res.sleep_entry_total;

endmodule

// File: design/bpsc_front.sv
// Input side: accept items, classify them and hold them in a two-entry queue.
module bpsc_front
    import bpsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_kind,
    input  logic [11:0] i_adc_raw,
    input  logic        i_vbus_high,
    input  logic [1:0]  i_wake_source,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;
    logic       w_pop;

    // Classify the incoming beat
    always_comb begin
        w_cmd.kind        = t_kind'(i_kind);
        w_cmd.adc_raw     = i_adc_raw;
        w_cmd.vbus_high   = i_vbus_high;
        w_cmd.wake_motion = (i_wake_source == 2'd1);
    end

    assign full        = (r_cnt == 2'd2);
    assign w_push      = push && !full;
    assign w_pop       = i_cmd_pop && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // Store the classified beat
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

// File: design/bpsc_back.sv
// Back end: sequencer that runs mode rules and sample averaging, plus result queue.
module bpsc_back
    import bpsc_pkg::*;
#(
    parameter int SAMPLE_DEPTH = 8,
    parameter int GRACE_MS     = 10000
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    output logic    empty,
    input  logic    pop,
    output t_result o_res
);

    localparam int          PTR_W = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam int          CNT_W = $clog2(SAMPLE_DEPTH + 1);
    localparam int          SUM_W = 13 + CNT_W;
    localparam int          IT_W  = $clog2(SUM_W + 1);
    localparam logic [31:0] GRACE = 32'(GRACE_MS);

    t_seq r_state;
    t_seq n_state;

    // Architectural state
    t_mode       r_mode;
    logic [31:0] r_since;
    logic [31:0] r_idle;
    logic [31:0] r_inm;
    logic [PTR_W-1:0] r_pos;
    logic        r_full;
    logic [SUM_W-1:0] r_sum;
    logic        r_low;
    logic        r_crit;
    logic        r_usb;
    logic [12:0] r_avg;
    logic [6:0]  r_pct;
    logic [31:0] r_wake;
    logic [31:0] r_sleep;
    logic [2:0]  r_ev;

    // Working registers
    t_cmd        r_cmd;
    logic [24:0] r_y;
    logic [12:0] r_q0;
    logic [12:0] r_mv;
    logic [12:0] r_old;
    logic [12:0] r_ring [SAMPLE_DEPTH];
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_div;
    logic [SUM_W-1:0] r_dvd;
    logic [SUM_W-1:0] r_quo;
    logic [IT_W-1:0]  r_iter;

    // Result queue
    t_result     r_obuf [2];
    logic        r_owp;
    logic        r_orp;
    logic [1:0]  r_ocnt;

    logic        w_res_push;
    logic        w_ofull;
    logic        w_opop;
    t_result     w_res;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            SEQ_IDLE: if (i_cmd_valid) n_state = SEQ_EXEC;
            SEQ_EXEC: n_state = (r_cmd.kind == KIND_SAMPLE) ? SEQ_MUL : SEQ_EMIT;
            SEQ_MUL:  n_state = SEQ_DIV;
            SEQ_DIV:  n_state = SEQ_CONV;
            SEQ_CONV: n_state = SEQ_ACC;
            SEQ_ACC:  n_state = SEQ_AVG;
            SEQ_AVG:  if (r_iter == IT_W'(1)) n_state = SEQ_PCT;
            SEQ_PCT:  n_state = SEQ_EMIT;
            SEQ_EMIT: if (!w_ofull) n_state = SEQ_IDLE;
            default:  n_state = SEQ_IDLE;
        endcase
    end

    // Sequencer strobes
    always_comb begin
        o_cmd_pop  = 1'b0;
        w_res_push = 1'b0;
        case (r_state)
            SEQ_IDLE: o_cmd_pop  = i_cmd_valid;
            SEQ_EMIT: w_res_push = !w_ofull;
            default: begin
                o_cmd_pop  = 1'b0;
                w_res_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Tick rules: counters advance first, then the mode table
    logic [31:0] tk_since;
    logic [31:0] tk_idle;
    logic [31:0] tk_inm;
    t_mode       tk_tgt;
    logic        tk_sleep;

    always_comb begin
        tk_since = sat_inc(r_since);
        tk_idle  = sat_inc(r_idle);
        tk_inm   = sat_inc(r_inm);
        tk_tgt   = r_mode;
        tk_sleep = 1'b0;
        case (r_mode)
            MODE_ACTIVE, MODE_MOTION: begin
                if (tk_since < GRACE) begin
                    if (r_usb) tk_tgt = MODE_USB;
                end else if (r_crit && !r_usb) begin
                    tk_tgt = MODE_CRIT;
                end else if (r_low && !r_usb) begin
                    tk_tgt = MODE_LOW;
                end else if (r_usb) begin
                    tk_tgt = MODE_USB;
                end else if (i_cfg.auto_sleep_enable
                             && tk_idle >= 32'(i_cfg.idle_to_light_ms)) begin
                    tk_sleep = 1'b1;
                    tk_tgt   = (i_cfg.deep_sleep_enable && i_cfg.light_to_deep_ms == 22'd0)
                               ? MODE_DEEP : MODE_LIGHT;
                end
            end
            MODE_LIGHT: begin
                if (i_cfg.deep_sleep_enable && i_cfg.light_to_deep_ms != 22'd0
                    && tk_inm >= 32'(i_cfg.light_to_deep_ms)) begin
                    tk_sleep = 1'b1;
                    tk_tgt   = MODE_DEEP;
                end
            end
            MODE_LOW: begin
                if (r_usb)       tk_tgt = MODE_USB;
                else if (!r_low) tk_tgt = MODE_ACTIVE;
                else if (r_crit) tk_tgt = MODE_CRIT;
            end
            MODE_CRIT: begin
                if (r_usb) begin
                    tk_tgt = MODE_USB;
                end else begin
                    tk_tgt   = MODE_DEEP;
                    tk_sleep = 1'b1;
                end
            end
            MODE_USB: begin
                if (!r_usb) begin
                    if (r_crit)     tk_tgt = MODE_CRIT;
                    else if (r_low) tk_tgt = MODE_LOW;
                    else            tk_tgt = MODE_ACTIVE;
                end
            end
            default: tk_tgt = r_mode;
        endcase
    end

    // Conversion correction: q0 may be one short of y / 4095
    logic [25:0]        cv_rem;
    logic [12:0]        cv_q;
    logic signed [14:0] cv_sum;
    logic [12:0]        cv_mv;

    always_comb begin
        cv_rem = {1'b0, r_y} - (({13'd0, r_q0} << 12) - {13'd0, r_q0});
        cv_q   = r_q0 + {12'd0, (cv_rem >= {13'd0, ADC_FULL})};
        cv_sum = $signed({2'b00, cv_q}) + 15'(i_cfg.calibration_offset_mv);
        if (cv_sum < 15'sd0) begin
            cv_mv = 13'd0;
        end else if (cv_sum > $signed({2'b00, MV_MAX})) begin
            cv_mv = MV_MAX;
        end else begin
            cv_mv = cv_sum[12:0];
        end
    end

    // Ring accumulate and new sample count
    logic [SUM_W-1:0] ac_sum;
    logic [PTR_W-1:0] ac_pos;
    logic             ac_full;
    logic [CNT_W-1:0] ac_cnt;

    always_comb begin
        ac_sum  = r_sum - (r_full ? SUM_W'(r_old) : SUM_W'(0)) + SUM_W'(r_mv);
        ac_pos  = (r_pos == PTR_W'(SAMPLE_DEPTH - 1)) ? PTR_W'(0) : r_pos + PTR_W'(1);
        ac_full = r_full || (ac_pos == PTR_W'(0));
        ac_cnt  = ac_full ? CNT_W'(SAMPLE_DEPTH) : CNT_W'(ac_pos);
    end

    // One restoring divide step
    logic [CNT_W:0]   dv_trial;
    logic             dv_ge;

    always_comb begin
        dv_trial = {r_rem, r_dvd[SUM_W-1]};
        dv_ge    = (dv_trial >= {1'b0, r_div});
    end

    // Percent curve and thresholds from the new average
    logic [12:0] pc_avg;
    logic [8:0]  pc_dhi;
    logic [9:0]  pc_dlo;
    logic [21:0] pc_phi;
    logic [21:0] pc_plo;
    logic [6:0]  pc_pct;

    always_comb begin
        pc_avg = r_quo[12:0];
        pc_dhi = 9'(pc_avg - MV_KNEE);
        pc_dlo = 10'(pc_avg - MV_EMPTY);
        pc_phi = 22'(pc_dhi) * 22'(RECIP_10);
        pc_plo = 22'(pc_dlo) * 22'(RECIP_14);
        if (pc_avg >= MV_FULL) begin
            pc_pct = 7'd100;
        end else if (pc_avg <= MV_EMPTY) begin
            pc_pct = 7'd0;
        end else if (pc_avg >= MV_KNEE) begin
            pc_pct = 7'd50 + 7'(pc_phi[21:16]);
        end else begin
            pc_pct = 7'(pc_plo[21:16]);
        end
    end

    // Sample memory: read old entry, write new one
    always_ff @(posedge i_clk) begin
        if (r_state == SEQ_MUL) begin
            r_old <= r_ring[r_pos];
        end
        if (r_state == SEQ_ACC) begin
            r_ring[r_pos] <= r_mv;
        end
    end

    // Datapath working registers
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        case (r_state)
            SEQ_MUL: r_y <= 25'(r_cmd.adc_raw) * 25'(ADC_SCALE) + ADC_ROUND;
            SEQ_DIV: r_q0 <= 13'(({12'd0, r_y} + ({12'd0, r_y} << 12)) >> 24);
            SEQ_CONV: r_mv <= i_cfg.monitoring_enable ? cv_mv : MV_NOMINAL;
            SEQ_ACC: begin
                r_rem  <= '0;
                r_dvd  <= ac_sum;
                r_div  <= ac_cnt;
                r_iter <= IT_W'(SUM_W);
            end
            SEQ_AVG: begin
                r_rem  <= dv_ge ? CNT_W'(dv_trial - {1'b0, r_div}) : CNT_W'(dv_trial);
                r_dvd  <= r_dvd << 1;
                r_quo  <= {r_quo[SUM_W-2:0], dv_ge};
                r_iter <= r_iter - IT_W'(1);
            end
            default: ;
        endcase
    end

    // Architectural state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_ACTIVE;
            r_since <= '0;
            r_idle  <= '0;
            r_inm   <= '0;
            r_pos   <= '0;
            r_full  <= 1'b0;
            r_sum   <= '0;
            r_low   <= 1'b0;
            r_crit  <= 1'b0;
            r_usb   <= 1'b0;
            r_avg   <= '0;
            r_pct   <= '0;
            r_wake  <= '0;
            r_sleep <= '0;
            r_ev    <= '0;
        end else begin
            case (r_state)
                SEQ_EXEC: begin
                    r_ev <= '0;
                    case (r_cmd.kind)
                        KIND_TICK: begin
                            r_since <= tk_since;
                            r_idle  <= tk_idle;
                            r_mode  <= tk_tgt;
                            r_inm   <= (tk_tgt != r_mode) ? 32'd0 : tk_inm;
                            if (tk_sleep) r_sleep <= sat_inc(r_sleep);
                        end
                        KIND_ACTIVITY: r_idle <= '0;
                        KIND_WAKE: begin
                            if (r_mode == MODE_LIGHT || r_mode == MODE_DEEP) begin
                                r_wake <= sat_inc(r_wake);
                                r_idle <= '0;
                                r_mode <= r_cmd.wake_motion ? MODE_MOTION : MODE_ACTIVE;
                                r_inm  <= '0;
                            end
                        end
                        default: ;
                    endcase
                end
                SEQ_ACC: begin
                    r_sum  <= ac_sum;
                    r_pos  <= ac_pos;
                    r_full <= ac_full;
                end
                SEQ_PCT: begin
                    r_avg  <= pc_avg;
                    r_pct  <= pc_pct;
                    r_usb  <= r_cmd.vbus_high;
                    r_low  <= pc_avg < i_cfg.low_threshold_mv;
                    r_crit <= pc_avg < i_cfg.critical_threshold_mv;
                    r_ev[2] <= r_cmd.vbus_high && !r_usb;
                    r_ev[1] <= (pc_avg < i_cfg.critical_threshold_mv) && !r_crit;
                    r_ev[0] <= !((pc_avg < i_cfg.critical_threshold_mv) && !r_crit)
                               && (pc_avg < i_cfg.low_threshold_mv) && !r_low;
                end
                default: ;
            endcase
        end
    end

    // Assemble the result beat
    always_comb begin
        w_res.power_mode        = r_mode;
        w_res.filtered_mv       = r_avg;
        w_res.charge_percent    = r_pct;
        w_res.battery_low       = r_low;
        w_res.battery_critical  = r_crit;
        w_res.usb_present       = r_usb;
        w_res.low_event         = r_ev[0];
        w_res.critical_event    = r_ev[1];
        w_res.usb_connect_event = r_ev[2];
        w_res.wake_total        = r_wake;
        w_res.sleep_entry_total = r_sleep;
    end

    assign w_ofull = (r_ocnt == 2'd2);
    assign w_opop  = pop && (r_ocnt != 2'd0);
    assign empty   = (r_ocnt == 2'd0);
    assign o_res   = r_obuf[r_orp];

    // Hold finished results
    always_ff @(posedge i_clk) begin
        if (w_res_push) begin
            r_obuf[r_owp] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (w_res_push) r_owp <= ~r_owp;
            if (w_opop)     r_orp <= ~r_orp;
            r_ocnt <= r_ocnt + {1'b0, w_res_push} - {1'b0, w_opop};
        end
    end

    // Checks
    a_ocnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= 2'd2)
        else $error("result queue overfilled");

    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SEQ_EMIT && !w_ofull) |=> (r_state == SEQ_IDLE))
        else $error("result beat not retired");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SEQ_AVG) |-> (r_rem < r_div))
        else $error("divider remainder out of range");

    a_sleep_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_sleep >= $past(r_sleep)))
        else $error("sleep count went down");

endmodule

// File: test/battery_power_state_controller_core_tb.sv
// Self-checking testbench of the battery power-state controller core.
module battery_power_state_controller_core_tb;
    import bpsc_pkg::*;

    localparam int RING_DEPTH   = 8;
    localparam int BOOT_MS      = 10000;
    localparam int BOOT_BEATS   = 200;
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_CYC   = 60;
    localparam logic [1:0] WAKE_BUTTON = 2'd0;
    localparam logic [1:0] WAKE_MOTION = 2'd1;
    localparam logic [1:0] WAKE_TIMER  = 2'd2;
    localparam logic [1:0] WAKE_SPARE  = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic [1:0]            i_kind;
    logic [11:0]           i_adc_raw;
    logic                  i_vbus_high;
    logic [1:0]            i_wake_source;
    logic                  empty;
    logic                  pop;
    logic [2:0]            o_power_mode;
    logic [12:0]           o_filtered_mv;
    logic [6:0]            o_charge_percent;
    logic                  o_battery_low;
    logic                  o_battery_critical;
    logic                  o_usb_present;
    logic                  o_low_event;
    logic                  o_critical_event;
    logic                  o_usb_connect_event;
    logic [31:0]           o_wake_total;
    logic [31:0]           o_sleep_entry_total;
    logic                  i_cfg_we;
    logic [2:0]            i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    battery_power_state_controller_core uut (.*);

    // Shadow configuration
    logic [21:0]        idle_limit_ms;
    logic [21:0]        deep_limit_ms;
    logic [12:0]        low_mv;
    logic [12:0]        crit_mv;
    logic signed [10:0] offset_mv;
    logic               auto_sleep;
    logic               deep_allowed;
    logic               monitor_on;

    // Shadow controller state
    t_mode       cur_mode;
    logic [31:0] boot_ms, idle_ms, mode_ms;
    logic [12:0] ring [RING_DEPTH];
    int          ring_pos;
    logic        ring_wrapped;
    int          ring_sum;
    logic [12:0] avg_mv;
    logic [6:0]  pct;
    logic        is_low, is_crit, on_usb;
    logic [31:0] wakes, sleeps;

    t_result status_fifo [$];
    int      fail_count;
    int      quiet_cycles;
    logic    send_rush;
    logic    pop_rush;
    int      pop_hold;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic switch_mode(input t_mode m);
        if (m != cur_mode) begin
            cur_mode = m;
            mode_ms  = '0;
        end
    endtask

    task automatic start_sleep(input t_mode m);
        switch_mode(m);
        sleeps = bump(sleeps);
    endtask

    function automatic logic [6:0] charge_of(input int mv);
        if (mv >= 4200) return 7'd100;
        if (mv <= 3000) return 7'd0;
        if (mv >= 3700) return 7'(50 + (mv - 3700) / 10);
        return 7'((mv - 3000) * 50 / 700);
    endfunction

    task automatic run_ms_rules();
        boot_ms = bump(boot_ms);
        idle_ms = bump(idle_ms);
        mode_ms = bump(mode_ms);
        case (cur_mode)
            MODE_ACTIVE, MODE_MOTION: begin
                if (boot_ms < BOOT_MS) begin
                    if (on_usb) switch_mode(MODE_USB);
                end else if (is_crit && !on_usb) switch_mode(MODE_CRIT);
                else if (is_low && !on_usb) switch_mode(MODE_LOW);
                else if (on_usb) switch_mode(MODE_USB);
                else if (auto_sleep && idle_ms >= {10'd0, idle_limit_ms}) begin
                    if (deep_allowed && deep_limit_ms == 0) start_sleep(MODE_DEEP);
                    else start_sleep(MODE_LIGHT);
                end
            end
            MODE_LIGHT: begin
                if (deep_allowed && deep_limit_ms != 0 && mode_ms >= {10'd0, deep_limit_ms})
                    start_sleep(MODE_DEEP);
            end
            MODE_LOW: begin
                if (on_usb) switch_mode(MODE_USB);
                else if (!is_low) switch_mode(MODE_ACTIVE);
                else if (is_crit) switch_mode(MODE_CRIT);
            end
            MODE_CRIT: begin
                if (on_usb) switch_mode(MODE_USB);
                else start_sleep(MODE_DEEP);
            end
            MODE_USB: begin
                if (!on_usb) begin
                    if (is_crit) switch_mode(MODE_CRIT);
                    else if (is_low) switch_mode(MODE_LOW);
                    else switch_mode(MODE_ACTIVE);
                end
            end
            default: ;
        endcase
    endtask

    // Advance the shadow controller by one accepted beat and queue its status
    task automatic predict_status(input logic [1:0] kind, input logic [11:0] raw,
                                  input logic vbus, input logic [1:0] src);
        t_result r;
        int      mv;
        int      cnt;
        logic    was_low, was_crit, was_usb;
        r = '0;
        case (t_kind'(kind))
            KIND_TICK: run_ms_rules();
            KIND_SAMPLE: begin
                was_low  = is_low;
                was_crit = is_crit;
                was_usb  = on_usb;
                if (monitor_on) begin
                    mv = (int'(raw) * 6600 + 2047) / 4095 + int'(offset_mv);
                    if (mv < 0) mv = 0;
                    if (mv > 8191) mv = 8191;
                end else begin
                    mv = 3800;
                end
                if (ring_wrapped) ring_sum -= int'(ring[ring_pos]);
                ring[ring_pos] = 13'(mv);
                ring_sum += mv;
                ring_pos = (ring_pos + 1) % RING_DEPTH;
                if (ring_pos == 0) ring_wrapped = 1'b1;
                cnt = ring_wrapped ? RING_DEPTH : ring_pos;
                avg_mv = 13'(ring_sum / cnt);
                pct = charge_of(int'(avg_mv));
                on_usb  = vbus;
                is_low  = avg_mv < low_mv;
                is_crit = avg_mv < crit_mv;
                r.usb_connect_event = on_usb && !was_usb;
                r.critical_event    = is_crit && !was_crit;
                r.low_event         = !r.critical_event && is_low && !was_low;
            end
            KIND_ACTIVITY: idle_ms = '0;
            default: begin
                if (cur_mode == MODE_LIGHT || cur_mode == MODE_DEEP) begin
                    wakes = bump(wakes);
                    idle_ms = '0;
                    switch_mode(src == WAKE_MOTION ? MODE_MOTION : MODE_ACTIVE);
                end
            end
        endcase
        r.power_mode        = cur_mode;
        r.filtered_mv       = avg_mv;
        r.charge_percent    = pct;
        r.battery_low       = is_low;
        r.battery_critical  = is_crit;
        r.usb_present       = on_usb;
        r.wake_total        = wakes;
        r.sleep_entry_total = sleeps;
        status_fifo.push_back(r);
    endtask

    // Send one beat; push stays high across back-to-back beats
    task automatic send_beat(input t_kind kind, input logic [11:0] raw,
                             input logic vbus, input logic [1:0] src);
        int gap;
        gap = send_rush ? 0 : gap_len();
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push          = 1'b1;
        i_kind        = kind;
        i_adc_raw     = raw;
        i_vbus_high   = vbus;
        i_wake_source = src;
        do @(posedge i_clk); while (full);
        predict_status(kind, raw, vbus, src);
        @(negedge i_clk);
    endtask

    task automatic drain_and_settle();
        push = 1'b0;
        while (status_fifo.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_IDLE_TO_LIGHT: idle_limit_ms = val;
            CFG_LIGHT_TO_DEEP: deep_limit_ms = val;
            CFG_LOW_TH:        low_mv = val[12:0];
            CFG_CRIT_TH:       crit_mv = val[12:0];
            CFG_CAL_OFFSET:    offset_mv = val[10:0];
            CFG_AUTO_SLEEP:    auto_sleep = val[0];
            CFG_DEEP_SLEEP:    deep_allowed = val[0];
            CFG_MONITOR:       monitor_on = val[0];
            default: ;
        endcase
    endtask

    task automatic write_all(input int idle, input int deep, input int lo, input int cr,
                             input int offs, input bit aut, input bit dp, input bit mon);
        drain_and_settle();
        write_reg(CFG_IDLE_TO_LIGHT, CFG_DATA_W'(idle));
        write_reg(CFG_LIGHT_TO_DEEP, CFG_DATA_W'(deep));
        write_reg(CFG_LOW_TH, CFG_DATA_W'(lo));
        write_reg(CFG_CRIT_TH, CFG_DATA_W'(cr));
        write_reg(CFG_CAL_OFFSET, CFG_DATA_W'(11'(offs)));
        write_reg(CFG_AUTO_SLEEP, CFG_DATA_W'(aut));
        write_reg(CFG_DEEP_SLEEP, CFG_DATA_W'(dp));
        write_reg(CFG_MONITOR, CFG_DATA_W'(mon));
    endtask

    // ADC range extremes, each kind, events, and boot-time USB handling
    task automatic test_directed();
        send_beat(KIND_SAMPLE, 12'd0, 1'b0, WAKE_BUTTON);     // monitoring off: nominal
        send_beat(KIND_TICK, 12'd0, 1'b0, WAKE_BUTTON);
        send_beat(KIND_WAKE, 12'd0, 1'b0, WAKE_MOTION);       // ignored while active
        write_all(5, 3, 3400, 3200, 1000, 1'b1, 1'b1, 1'b1);
        send_beat(KIND_SAMPLE, 12'hFFF, 1'b1, WAKE_SPARE);    // top of range, usb connect
        send_beat(KIND_TICK, 12'd0, 1'b0, WAKE_BUTTON);       // boot grace: go usb
        send_beat(KIND_ACTIVITY, 12'hFFF, 1'b1, WAKE_SPARE);
        write_all(5, 3, 3400, 3200, -1000, 1'b1, 1'b1, 1'b1);
        repeat (8) send_beat(KIND_SAMPLE, 12'd0, 1'b0, WAKE_BUTTON); // clamp low, critical
        send_beat(KIND_TICK, 12'd0, 1'b0, WAKE_BUTTON);
        send_beat(KIND_TICK, 12'd0, 1'b0, WAKE_BUTTON);
        write_all(5, 3, 3400, 1000, 0, 1'b1, 1'b1, 1'b1);
        send_beat(KIND_SAMPLE, 12'd1000, 1'b0, WAKE_BUTTON);  // still low and critical
        send_beat(KIND_SAMPLE, 12'd2482, 1'b1, WAKE_TIMER);
        send_beat(KIND_WAKE, 12'd0, 1'b0, WAKE_SPARE);
        send_beat(KIND_TICK, 12'd0, 1'b1, WAKE_BUTTON);
    endtask

    // Run mostly ticks inside the boot grace period with USB changes
    task automatic test_boot_grace();
        int r;
        send_rush = 1'b1;
        repeat (BOOT_BEATS) begin
            r = $urandom_range(0, 99);
            if (r < 96) send_beat(KIND_TICK, 12'd0, 1'b0, WAKE_BUTTON);
            else if (r < 98)
                send_beat(KIND_SAMPLE, 12'($urandom_range(2000, 2600)),
                          1'($urandom), 2'($urandom));
            else send_beat(KIND_ACTIVITY, 12'($urandom), 1'($urandom), 2'($urandom));
        end
        send_beat(KIND_SAMPLE, 12'd2400, 1'b0, WAKE_BUTTON);
        send_rush = 1'b0;
    endtask

    // Random beats under one configuration
    task automatic test_random_phase(input int count, input bit rush);
        int          r;
        t_kind       k;
        logic [11:0] raw;
        send_rush = rush;
        pop_rush  = rush;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 55) k = KIND_TICK;
            else if (r < 72) k = KIND_SAMPLE;
            else if (r < 82) k = KIND_ACTIVITY;
            else k = KIND_WAKE;
            r = $urandom_range(0, 9);
            raw = (r < 8) ? 12'($urandom_range(1800, 2700)) : 12'($urandom);
            send_beat(k, raw, ($urandom_range(0, 9) < 3), 2'($urandom));
        end
        send_rush = 1'b0;
        pop_rush  = 1'b0;
    endtask

    task automatic test_settings_sweep();
        write_all(0, 0, 8191, 0, 0, 1'b1, 1'b1, 1'b1);
        test_random_phase(150, 1'b0);
        write_all(3600000, 3600000, 0, 8191, 1000, 1'b1, 1'b1, 1'b1);
        test_random_phase(120, 1'b1);
        write_all(8, 0, 3500, 3300, -1000, 1'b1, 1'b0, 1'b1);
        test_random_phase(200, 1'b0);
        write_all(0, 12, 3400, 3200, 0, 1'b0, 1'b1, 1'b0);
        test_random_phase(150, 1'b0);
        repeat (8) begin
            write_all($urandom_range(0, 25), $urandom_range(0, 15),
                      $urandom_range(3000, 4000), $urandom_range(2900, 3600),
                      $urandom_range(0, 2000) - 1000, ($urandom_range(0, 4) != 0),
                      ($urandom_range(0, 3) != 0), ($urandom_range(0, 5) != 0));
            test_random_phase(100, ($urandom_range(0, 4) == 0));
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && pop && !empty) begin
            if (status_fifo.size() == 0) begin
                $error("status beat with nothing expected");
                fail_count++;
            end else begin
                e = status_fifo.pop_front();
                if (o_power_mode != e.power_mode) begin
                    $error("power_mode exp %0d got %0d", e.power_mode, o_power_mode);
                    fail_count++;
                end
                if (o_filtered_mv != e.filtered_mv) begin
                    $error("filtered_mv exp %0d got %0d", e.filtered_mv, o_filtered_mv);
                    fail_count++;
                end
                if (o_charge_percent != e.charge_percent) begin
                    $error("charge_percent exp %0d got %0d", e.charge_percent, o_charge_percent);
                    fail_count++;
                end
                if (o_battery_low != e.battery_low) begin
                    $error("battery_low exp %0d got %0d", e.battery_low, o_battery_low);
                    fail_count++;
                end
                if (o_battery_critical != e.battery_critical) begin
                    $error("battery_critical exp %0d got %0d", e.battery_critical,
                           o_battery_critical);
                    fail_count++;
                end
                if (o_usb_present != e.usb_present) begin
                    $error("usb_present exp %0d got %0d", e.usb_present, o_usb_present);
                    fail_count++;
                end
                if (o_low_event != e.low_event) begin
                    $error("low_event exp %0d got %0d", e.low_event, o_low_event);
                    fail_count++;
                end
                if (o_critical_event != e.critical_event) begin
                    $error("critical_event exp %0d got %0d", e.critical_event, o_critical_event);
                    fail_count++;
                end
                if (o_usb_connect_event != e.usb_connect_event) begin
                    $error("usb_connect_event exp %0d got %0d", e.usb_connect_event,
                           o_usb_connect_event);
                    fail_count++;
                end
                if (o_wake_total != e.wake_total) begin
                    $error("wake_total exp %0d got %0d", e.wake_total, o_wake_total);
                    fail_count++;
                end
                if (o_sleep_entry_total != e.sleep_entry_total) begin
                    $error("sleep_entry_total exp %0d got %0d", e.sleep_entry_total,
                           o_sleep_entry_total);
                    fail_count++;
                end
            end
        end
    end

    // Drive pop with random stalls, short mostly, a few long
    initial begin
        pop = 1'b0;
        pop_hold = 0;
        forever begin
            @(negedge i_clk);
            if (pop_rush) begin
                pop = 1'b1;
            end else if (pop_hold > 0) begin
                pop = 1'b0;
                pop_hold--;
            end else if ($urandom_range(0, 99) < 75) begin
                pop = 1'b1;
            end else begin
                pop = 1'b0;
                pop_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 2);
            end
        end
    end

    // Watchdog: count cycles without any accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("battery_power_state_controller_core_tb failed");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        i_kind = KIND_TICK;
        i_adc_raw = '0;
        i_vbus_high = 1'b0;
        i_wake_source = WAKE_BUTTON;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_IDLE_TO_LIGHT;
        i_cfg_data = '0;
        fail_count = 0;
        quiet_cycles = 0;
        send_rush = 1'b0;
        pop_rush = 1'b0;
        idle_limit_ms = 22'd180000;
        deep_limit_ms = 22'd60000;
        low_mv = 13'd3400;
        crit_mv = 13'd3200;
        offset_mv = '0;
        auto_sleep = 1'b1;
        deep_allowed = 1'b1;
        monitor_on = 1'b0;
        cur_mode = MODE_ACTIVE;
        boot_ms = '0;
        idle_ms = '0;
        mode_ms = '0;
        ring_pos = 0;
        ring_wrapped = 1'b0;
        ring_sum = 0;
        avg_mv = '0;
        pct = '0;
        is_low = 1'b0;
        is_crit = 1'b0;
        on_usb = 1'b0;
        wakes = '0;
        sleeps = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_boot_grace();
        test_settings_sweep();

        drain_and_settle();
        if (fail_count == 0 && status_fifo.size() == 0) begin
            $display("battery_power_state_controller_core_tb passed");
        end else begin
            $display("battery_power_state_controller_core_tb failed");
        end
        $finish;
    end

endmodule
